/* hw/rtl/sad3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sad3_pkg
// Shared types and constants for the masked 3x3 SAD unit.
// ----------------------------------------------------------------------------
package sad3_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int WIN_N      = 9;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CFG_W = 13;
  localparam int PIX_W = 8;
  localparam int SUM_W = 32;
  localparam int OFS_W = 4;
  localparam int CIDX_W = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MASK_ENABLE  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_MASK_INDEX   = 2'd3;

  localparam logic [OFS_W-1:0] LAST_OFFSET = OFS_W'(WIN_N - 1);

  typedef struct packed {
    logic [PIX_W-1:0] current_pixel;
    logic [PIX_W-1:0] background_pixel;
    logic [PIX_W-1:0] mask_pixel;
  } sad3_in_t;

  typedef struct packed {
    logic [OFS_W-1:0] offset_number;
    logic [SUM_W-1:0] diff_sum;
    logic             last_of_run;
  } sad3_out_t;

  // one line store entry: current/mask of the last row, background of two rows
  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] msk;
    logic [PIX_W-1:0] bg_odd;
    logic [PIX_W-1:0] bg_even;
  } sad3_line_t;

  typedef logic [WIN_N-1:0][SUM_W-1:0] sad3_sums_t;

  // control from the pixel pipeline to the accumulator bank
  typedef struct packed {
    logic fire;
    logic frame_end;
    logic win_ok;
    logic older;
  } sad3_acc_ctl_t;

endpackage : sad3_pkg
`default_nettype wire

/* hw/rtl/sad3_line_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sad3_line_ram
// Line store, one write and one registered read port.
// ----------------------------------------------------------------------------
module sad3_line_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [sad3_pkg::COL_W-1:0] waddr,
  input  sad3_pkg::sad3_line_t     wdata,
  input  logic                     re,
  input  logic [sad3_pkg::COL_W-1:0] raddr,
  output sad3_pkg::sad3_line_t     rdata
);
  import sad3_pkg::*;

  sad3_line_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : sad3_line_ram
`default_nettype wire

/* hw/rtl/sad3_accum.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sad3_accum
// Background window, center delay and the nine SAD accumulators.
// ----------------------------------------------------------------------------
module sad3_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sad3_pkg::sad3_acc_ctl_t     ctl,
  input  sad3_pkg::sad3_line_t        rd_entry,
  input  logic [sad3_pkg::PIX_W-1:0]  bg_in,
  input  logic                        mask_enable,
  input  logic [sad3_pkg::PIX_W-1:0]  mask_index,
  output sad3_pkg::sad3_sums_t        sums_nxt
);
  import sad3_pkg::*;

  logic [2:0][1:0][PIX_W-1:0] win_r;
  logic [2*PIX_W-1:0]         center_r;
  sad3_sums_t                 acc_r;
  logic [2:0][PIX_W-1:0]      column;
  logic                       count_en;
  logic [PIX_W-1:0]           cval;

  // rows r-2, r-1 and r of the newest column
  assign column[0] = ctl.older ? rd_entry.bg_odd  : rd_entry.bg_even;
  assign column[1] = ctl.older ? rd_entry.bg_even : rd_entry.bg_odd;
  assign column[2] = bg_in;

  assign cval     = center_r[2*PIX_W-1:PIX_W];
  assign count_en = ctl.win_ok && (!mask_enable || (center_r[PIX_W-1:0] == mask_index));

  for (genvar k = 0; k < WIN_N; k++) begin : g_tap
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] d;
    if ((k % 3) == 2) begin : g_new
      assign b = column[k / 3];
    end else begin : g_old
      assign b = win_r[k / 3][k % 3];
    end
    assign d = (cval > b) ? (cval - b) : (b - cval);
    assign sums_nxt[k] = acc_r[k] + (count_en ? {{(SUM_W-PIX_W){1'b0}}, d} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      center_r <= '0;
      acc_r    <= '0;
    end else if (ctl.fire) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= column[i];
      end
      center_r <= {rd_entry.cur, rd_entry.msk};
      acc_r    <= ctl.frame_end ? '0 : sums_nxt;
    end
  end

endmodule : sad3_accum
`default_nettype wire

/* hw/rtl/sad3_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sad3_out_buf
// Holds a frame's nine sums and shifts them out one per transaction.
// ----------------------------------------------------------------------------
module sad3_out_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  sad3_pkg::sad3_sums_t       sums,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sad3_pkg::sad3_out_t        out_data
);
  import sad3_pkg::*;

  sad3_sums_t       buf_r;
  logic [OFS_W-1:0] idx_r;
  logic             busy_r;
  logic             take;
  logic             last_take;

  assign take      = busy_r && out_ready;
  assign last_take = take && (idx_r == LAST_OFFSET);
  // the next frame may load in the cycle the last sum leaves
  assign busy      = busy_r && !last_take;
  assign out_valid = busy_r;

  assign out_data.offset_number = idx_r;
  assign out_data.diff_sum      = buf_r[0];
  assign out_data.last_of_run   = (idx_r == LAST_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (take) begin
      busy_r <= (idx_r != LAST_OFFSET);
      idx_r  <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= sums;
    end else if (take) begin
      for (int i = 0; i < WIN_N - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule : sad3_out_buf
`default_nettype wire

/* hw/rtl/sad_3x3_neighbourhood_masked_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sad_3x3_neighbourhood_masked_unit
// Masked 3x3-shift sum of absolute differences over a raster-scanned frame.
// ----------------------------------------------------------------------------
// Throughput: one pixel transaction per cycle but for the input stall below.
// Output: the first sum is valid once the frame's last pixel has left stage 1
//   and loaded the output buffer; the nine sums then leave one per cycle while
//   out_ready is high. Input stalls only when a frame ends while the previous
//   frame's sums are still draining.
// Reset: synchronous, active low; clears counters, valid flags, window, sums and config, not the line store.
// ----------------------------------------------------------------------------
module sad_3x3_neighbourhood_masked_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sad3_pkg::sad3_in_t               in_data,
  // sums out
  output logic                             out_valid,
  input  logic                             out_ready,
  output sad3_pkg::sad3_out_t              out_data,
  // configuration
  input  logic                             cfg_we,
  input  logic [sad3_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [sad3_pkg::CFG_W-1:0]       cfg_wdata
);
  import sad3_pkg::*;

  localparam logic [CFG_W-1:0] MIN_SIZE  = CFG_W'(3);
  localparam logic [CFG_W-1:0] MAX_W_C   = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] MAX_H_C   = CFG_W'(MAX_HEIGHT);

  // configuration registers
  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic             mask_enable_r;
  logic [PIX_W-1:0] mask_index_r;

  // raster position of the next pixel
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // stage 1: pixel whose line store entry is being read back
  logic             s1_valid_r;
  sad3_in_t         s1_data_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_win_ok_r;
  logic             s1_older_r;
  logic             s1_end_r;

  logic [CFG_W-1:0] w_eff, h_eff;
  logic             accept, s1_fire;
  logic             row_end, frame_end;
  logic             ob_busy;

  sad3_line_t       rd_entry, wr_entry;
  sad3_acc_ctl_t    acc_ctl;
  sad3_sums_t       sums_nxt;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= MIN_SIZE;
      frame_height_r <= MIN_SIZE;
      mask_enable_r  <= 1'b0;
      mask_index_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        CFG_MASK_ENABLE:  mask_enable_r  <= cfg_wdata[0];
        CFG_MASK_INDEX:   mask_index_r   <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range sizes clamp to 3..max
  always_comb begin
    if (frame_width_r < MIN_SIZE)      w_eff = MIN_SIZE;
    else if (frame_width_r > MAX_W_C)  w_eff = MAX_W_C;
    else                               w_eff = frame_width_r;
    if (frame_height_r < MIN_SIZE)     h_eff = MIN_SIZE;
    else if (frame_height_r > MAX_H_C) h_eff = MAX_H_C;
    else                               h_eff = frame_height_r;
  end

  // ------------------------------------------------------------- handshake
  // A frame's last pixel waits in stage 1 until the output buffer is free;
  // otherwise stage 1 retires every cycle and a new pixel can enter behind it.
  assign s1_fire  = s1_valid_r && !(s1_end_r && ob_busy);
  assign in_ready = !s1_valid_r || s1_fire;
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------- position count
  assign row_end   = (CFG_W'(col_r) + 1'b1) >= w_eff;
  assign frame_end = row_end && ((CFG_W'(row_r) + 1'b1) >= h_eff);

  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (row_end) begin
      col_nxt = '0;
      row_nxt = frame_end ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept)       s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r   <= in_data;
      s1_col_r    <= col_r;
      s1_win_ok_r <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_older_r  <= row_r[0];   // slot that holds row r-2
      s1_end_r    <= frame_end;
    end
  end

  // ------------------------------------------------------------ line store
  // Read at accept, write back when the pixel retires from stage 1.
  // Consecutive pixels never share a column, so no forwarding is needed.
  always_comb begin
    wr_entry     = rd_entry;
    wr_entry.cur = s1_data_r.current_pixel;
    wr_entry.msk = s1_data_r.mask_pixel;
    if (s1_older_r) wr_entry.bg_odd  = s1_data_r.background_pixel;
    else            wr_entry.bg_even = s1_data_r.background_pixel;
  end

  sad3_line_ram u_line_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (col_r),
    .rdata (rd_entry)
  );

  // ----------------------------------------------------------- accumulators
  assign acc_ctl.fire      = s1_fire;
  assign acc_ctl.frame_end = s1_end_r;
  assign acc_ctl.win_ok    = s1_win_ok_r;
  assign acc_ctl.older     = s1_older_r;

  sad3_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (acc_ctl),
    .rd_entry    (rd_entry),
    .bg_in       (s1_data_r.background_pixel),
    .mask_enable (mask_enable_r),
    .mask_index  (mask_index_r),
    .sums_nxt    (sums_nxt)
  );

  // ---------------------------------------------------------------- output
  sad3_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_fire && s1_end_r),
    .sums      (sums_nxt),
    .busy      (ob_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : sad_3x3_neighbourhood_masked_unit
`default_nettype wire
